[hw/rtl/uvam_pkg.sv]
package uvam_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 24;
    localparam int TEX_W     = 18;
    localparam int OUT_W     = 32;

    localparam int A_W       = POS_W + 1;
    localparam int E_W       = TEX_W + 1;
    localparam int LO_W      = 19;
    localparam int B_W       = LO_W + 1;
    localparam int COF_W     = 2 * TEX_W + 1;
    localparam int DET_W     = COF_W + 2;
    localparam int PROD_W    = A_W + B_W;
    localparam int ACC_W     = 64;

    localparam int NA_MAG_W  = A_W + E_W;
    localparam int NC_MAG_W  = POS_W + COF_W;
    localparam int DIV_W     = (NA_MAG_W + FRAC_BITS > NC_MAG_W) ?
                               (NA_MAG_W + FRAC_BITS) : NC_MAG_W;
    localparam int CNT_W     = $clog2(DIV_W + 1);

    localparam int NUM_N     = 9;
    localparam int IDX_W     = $clog2(NUM_N);

    typedef logic [IDX_W-1:0] dst_t;

    localparam dst_t DST_COF0 = IDX_W'(0);
    localparam dst_t DST_COF1 = IDX_W'(1);
    localparam dst_t DST_COF2 = IDX_W'(2);
    localparam dst_t DST_NUM0 = IDX_W'(3);
    localparam dst_t DST_LAST = IDX_W'(11);

    localparam logic [1:0] CORNER_0    = 2'd0;
    localparam logic [1:0] CORNER_1    = 2'd1;
    localparam logic [1:0] CORNER_2    = 2'd2;
    localparam logic [1:0] CORNER_NONE = 2'd3;

    typedef struct packed {
        logic valid;
        logic clear;
        logic sub;
        logic hi;
        logic last;
        dst_t dst;
    } mac_op_t;

    typedef struct packed {
        logic done;
        dst_t dst;
    } mac_res_t;

    typedef struct packed {
        logic start;
        logic shift;
    } div_req_t;

endpackage

[hw/rtl/uvam_mac.sv]
module uvam_mac
    import uvam_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_op_t                  op,
    input  logic signed [A_W-1:0]    a,
    input  logic signed [B_W-1:0]    b,
    output mac_res_t                 res,
    output logic signed [ACC_W-1:0]  acc
);

    logic signed [PROD_W-1:0] prod_reg;
    mac_op_t                  op_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  base;
    mac_res_t                 res_reg;

    always_comb
    begin
        term = ACC_W'(prod_reg);
        if (op_reg.hi)
        begin
            term = term <<< LO_W;
        end
        base = op_reg.clear ? '0 : acc_reg;
        acc_next = op_reg.sub ? (base - term) : (base + term);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= '0;
            res_reg <= '0;
        end
        else
        begin
            op_reg       <= op;
            res_reg.done <= op_reg.valid && op_reg.last;
            res_reg.dst  <= op_reg.dst;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a * b;
        if (op_reg.valid)
        begin
            acc_reg <= acc_next;
        end
    end

    assign res = res_reg;
    assign acc = acc_reg;

endmodule

[hw/rtl/uvam_div.sv]
module uvam_div
    import uvam_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  div_req_t                 req,
    input  logic signed [ACC_W-1:0]  num,
    input  logic signed [DET_W-1:0]  den,
    output logic                     busy,
    output logic                     done,
    output logic [OUT_W-1:0]         quo
);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              fin_reg;
    logic              neg_reg;
    logic [DIV_W-1:0]  dvd_reg;
    logic [DET_W-1:0]  rem_reg;
    logic [DET_W-1:0]  dmag_reg;
    logic [ACC_W-1:0]  n_mag;
    logic [DIV_W-1:0]  n_load;
    logic [DET_W:0]    trial;
    logic              ge;
    logic [DET_W:0]    diff;
    logic              big;

    always_comb
    begin
        n_mag  = num[ACC_W-1] ? (ACC_W'(0) - ACC_W'(num)) : ACC_W'(num);
        n_load = n_mag[DIV_W-1:0];
        if (req.shift)
        begin
            n_load = n_load << FRAC_BITS;
        end
        trial = {rem_reg, dvd_reg[DIV_W-1]};
        ge    = trial >= {1'b0, dmag_reg};
        diff  = trial - {1'b0, dmag_reg};
        big   = |dvd_reg[DIV_W-1:OUT_W-1];
        if (neg_reg)
        begin
            quo = big ? {1'b1, {(OUT_W-1){1'b0}}} : (OUT_W'(0) - dvd_reg[OUT_W-1:0]);
        end
        else
        begin
            quo = big ? {1'b0, {(OUT_W-1){1'b1}}} : dvd_reg[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            fin_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg  <= num[ACC_W-1] ^ den[DET_W-1];
            dvd_reg  <= n_load;
            rem_reg  <= '0;
            dmag_reg <= den[DET_W-1] ? (DET_W'(0) - DET_W'(den)) : DET_W'(den);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DET_W-1:0] : trial[DET_W-1:0];
            dvd_reg <= {dvd_reg[DIV_W-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign done = fin_reg;

endmodule

[hw/rtl/uv_to_position_affine_map.sv]
// Corners 0 and 1 are stored.
// Corner 2: 36 multiply-accumulate operations on the shared 25x20 multiplier, then nine
// restoring divisions of 61 steps each on the shared divider (none for a singular triangle).
// in_stall stays high from the acceptance of corner 2 until the result is loaded into the
// output registers, which raises out_valid; it stays high longer while a previous result
// is stalled.
// Reset (rst_n, async, active low) clears control state; stored corners are undefined.
module uv_to_position_affine_map
    import uvam_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [POS_W-1:0]  pos_x,
    input  logic signed [POS_W-1:0]  pos_y,
    input  logic signed [POS_W-1:0]  pos_z,
    input  logic signed [TEX_W-1:0]  tex_u,
    input  logic signed [TEX_W-1:0]  tex_v,
    input  logic [1:0]               corner,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [OUT_W-1:0]  du_x,
    output logic signed [OUT_W-1:0]  du_y,
    output logic signed [OUT_W-1:0]  du_z,
    output logic signed [OUT_W-1:0]  dv_x,
    output logic signed [OUT_W-1:0]  dv_y,
    output logic signed [OUT_W-1:0]  dv_z,
    output logic signed [OUT_W-1:0]  org_x,
    output logic signed [OUT_W-1:0]  org_y,
    output logic signed [OUT_W-1:0]  org_z,
    output logic                     singular
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_MAC    = 6'b000010,
        ST_DRAIN  = 6'b000100,
        ST_DSTART = 6'b001000,
        ST_DWAIT  = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

    state_t state_reg;
    logic   cofph_reg;
    logic [3:0] sub_reg;
    logic [1:0] k_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [1:0] j_reg;
    logic   sing_reg;
    logic   out_valid_reg;

    logic signed [POS_W-1:0] pos_reg [3][3];
    logic signed [TEX_W-1:0] u_reg [3];
    logic signed [TEX_W-1:0] v_reg [3];
    logic signed [COF_W-1:0] cof_reg [3];
    logic signed [ACC_W-1:0] num_reg [NUM_N];
    logic [OUT_W-1:0]        res_reg [NUM_N];
    logic [OUT_W-1:0]        o_reg [NUM_N];
    logic                    sing_out_reg;

    mac_op_t                 mop;
    logic signed [A_W-1:0]   ma;
    logic signed [B_W-1:0]   mb;
    mac_res_t                mres;
    logic signed [ACC_W-1:0] macc;
    div_req_t                dreq;
    logic                    dbusy;
    logic                    ddone;
    logic [OUT_W-1:0]        dquo;

    logic signed [A_W-1:0]   d1;
    logic signed [A_W-1:0]   d2;
    logic signed [E_W-1:0]   e1u;
    logic signed [E_W-1:0]   e1v;
    logic signed [E_W-1:0]   e2u;
    logic signed [E_W-1:0]   e2v;
    logic signed [DET_W-1:0] det;
    logic [IDX_W-1:0]        kdst;
    logic                    accept_in;
    logic                    load_out;
    logic [IDX_W-1:0]        num_idx;

    assign accept_in = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = state_reg != ST_IDLE;
    assign load_out  = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);
    assign num_idx   = mres.dst - DST_NUM0;

    always_comb
    begin
        d1  = A_W'(pos_reg[1][0]) - A_W'(pos_reg[0][0]);
        d2  = A_W'(pos_reg[2][0]) - A_W'(pos_reg[0][0]);
        e1u = E_W'(u_reg[1]) - E_W'(u_reg[0]);
        e1v = E_W'(v_reg[1]) - E_W'(v_reg[0]);
        e2u = E_W'(u_reg[2]) - E_W'(u_reg[0]);
        e2v = E_W'(v_reg[2]) - E_W'(v_reg[0]);
        det = DET_W'(cof_reg[0]) + DET_W'(cof_reg[1]) + DET_W'(cof_reg[2]);
        kdst = DST_NUM0 + IDX_W'({k_reg, 1'b0}) + IDX_W'(k_reg);
    end

    always_comb
    begin
        mop       = '0;
        mop.valid = state_reg == ST_MAC;
        ma        = '0;
        mb        = '0;
        if (cofph_reg)
        begin
            unique case (sub_reg)
                4'd0:
                begin
                    ma = A_W'(u_reg[1]); mb = B_W'(v_reg[2]);
                    mop.clear = 1'b1; mop.dst = DST_COF0;
                end
                4'd1:
                begin
                    ma = A_W'(u_reg[2]); mb = B_W'(v_reg[1]);
                    mop.sub = 1'b1; mop.last = 1'b1; mop.dst = DST_COF0;
                end
                4'd2:
                begin
                    ma = A_W'(u_reg[2]); mb = B_W'(v_reg[0]);
                    mop.clear = 1'b1; mop.dst = DST_COF1;
                end
                4'd3:
                begin
                    ma = A_W'(u_reg[0]); mb = B_W'(v_reg[2]);
                    mop.sub = 1'b1; mop.last = 1'b1; mop.dst = DST_COF1;
                end
                4'd4:
                begin
                    ma = A_W'(u_reg[0]); mb = B_W'(v_reg[1]);
                    mop.clear = 1'b1; mop.dst = DST_COF2;
                end
                default:
                begin
                    ma = A_W'(u_reg[1]); mb = B_W'(v_reg[0]);
                    mop.sub = 1'b1; mop.last = 1'b1; mop.dst = DST_COF2;
                end
            endcase
        end
        else
        begin
            unique case (sub_reg)
                4'd0:
                begin
                    ma = d1; mb = B_W'(e2v); mop.clear = 1'b1; mop.dst = kdst;
                end
                4'd1:
                begin
                    ma = d2; mb = B_W'(e1v); mop.sub = 1'b1; mop.last = 1'b1;
                    mop.dst = kdst;
                end
                4'd2:
                begin
                    ma = d2; mb = B_W'(e1u); mop.clear = 1'b1;
                    mop.dst = kdst + IDX_W'(1);
                end
                4'd3:
                begin
                    ma = d1; mb = B_W'(e2u); mop.sub = 1'b1; mop.last = 1'b1;
                    mop.dst = kdst + IDX_W'(1);
                end
                4'd4:
                begin
                    ma = A_W'(pos_reg[0][0]);
                    mb = B_W'($signed(cof_reg[0][COF_W-1:LO_W]));
                    mop.clear = 1'b1; mop.hi = 1'b1; mop.dst = kdst + IDX_W'(2);
                end
                4'd5:
                begin
                    ma = A_W'(pos_reg[0][0]);
                    mb = $signed({1'b0, cof_reg[0][LO_W-1:0]});
                    mop.dst = kdst + IDX_W'(2);
                end
                4'd6:
                begin
                    ma = A_W'(pos_reg[1][0]);
                    mb = B_W'($signed(cof_reg[1][COF_W-1:LO_W]));
                    mop.hi = 1'b1; mop.dst = kdst + IDX_W'(2);
                end
                4'd7:
                begin
                    ma = A_W'(pos_reg[1][0]);
                    mb = $signed({1'b0, cof_reg[1][LO_W-1:0]});
                    mop.dst = kdst + IDX_W'(2);
                end
                4'd8:
                begin
                    ma = A_W'(pos_reg[2][0]);
                    mb = B_W'($signed(cof_reg[2][COF_W-1:LO_W]));
                    mop.hi = 1'b1; mop.dst = kdst + IDX_W'(2);
                end
                default:
                begin
                    ma = A_W'(pos_reg[2][0]);
                    mb = $signed({1'b0, cof_reg[2][LO_W-1:0]});
                    mop.last = 1'b1; mop.dst = kdst + IDX_W'(2);
                end
            endcase
        end
    end

    always_comb
    begin
        dreq.start = (state_reg == ST_DSTART) && (det != '0);
        dreq.shift = j_reg != 2'd2;
    end

    uvam_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .op    (mop),
        .a     (ma),
        .b     (mb),
        .res   (mres),
        .acc   (macc)
    );

    uvam_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .num   (num_reg[idx_reg]),
        .den   (det),
        .busy  (dbusy),
        .done  (ddone),
        .quo   (dquo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cofph_reg     <= 1'b0;
            sub_reg       <= '0;
            k_reg         <= '0;
            idx_reg       <= '0;
            j_reg         <= '0;
            sing_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept_in && corner == CORNER_2)
                    begin
                        state_reg <= ST_MAC;
                        cofph_reg <= 1'b1;
                        sub_reg   <= '0;
                        k_reg     <= '0;
                        sing_reg  <= 1'b0;
                    end
                end
                ST_MAC:
                begin
                    if (cofph_reg && sub_reg == 4'd5)
                    begin
                        cofph_reg <= 1'b0;
                        sub_reg   <= '0;
                    end
                    else if (!cofph_reg && sub_reg == 4'd9)
                    begin
                        sub_reg <= '0;
                        k_reg   <= k_reg + 2'd1;
                        if (k_reg == 2'd2)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                    end
                    else
                    begin
                        sub_reg <= sub_reg + 4'd1;
                    end
                end
                ST_DRAIN:
                begin
                    if (mres.done && mres.dst == DST_LAST)
                    begin
                        state_reg <= ST_DSTART;
                        idx_reg   <= '0;
                        j_reg     <= '0;
                    end
                end
                ST_DSTART:
                begin
                    if (det == '0)
                    begin
                        sing_reg  <= 1'b1;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_DWAIT;
                    end
                end
                ST_DWAIT:
                begin
                    if (ddone)
                    begin
                        if (idx_reg == IDX_W'(NUM_N - 1))
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_DSTART;
                            idx_reg   <= idx_reg + IDX_W'(1);
                            j_reg     <= (j_reg == 2'd2) ? 2'd0 : j_reg + 2'd1;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (load_out)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in && corner != CORNER_NONE)
        begin
            pos_reg[corner][0] <= pos_x;
            pos_reg[corner][1] <= pos_y;
            pos_reg[corner][2] <= pos_z;
            u_reg[corner]      <= tex_u;
            v_reg[corner]      <= tex_v;
        end
        // rotate axes so the current one sits in lane 0; three turns restore order
        if (state_reg == ST_MAC && !cofph_reg && sub_reg == 4'd9)
        begin
            for (int s = 0; s < 3; s++)
            begin
                pos_reg[s][0] <= pos_reg[s][1];
                pos_reg[s][1] <= pos_reg[s][2];
                pos_reg[s][2] <= pos_reg[s][0];
            end
        end
        if (mres.done)
        begin
            priority if (mres.dst == DST_COF0)
            begin
                cof_reg[0] <= macc[COF_W-1:0];
            end
            else if (mres.dst == DST_COF1)
            begin
                cof_reg[1] <= macc[COF_W-1:0];
            end
            else if (mres.dst == DST_COF2)
            begin
                cof_reg[2] <= macc[COF_W-1:0];
            end
            else
            begin
                num_reg[num_idx] <= macc;
            end
        end
        if (state_reg == ST_DWAIT && ddone)
        begin
            res_reg[idx_reg] <= dquo;
        end
        if (load_out)
        begin
            for (int i = 0; i < NUM_N; i++)
            begin
                o_reg[i] <= sing_reg ? '0 : res_reg[i];
            end
            sing_out_reg <= sing_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign du_x      = o_reg[0];
    assign dv_x      = o_reg[1];
    assign org_x     = o_reg[2];
    assign du_y      = o_reg[3];
    assign dv_y      = o_reg[4];
    assign org_y     = o_reg[5];
    assign du_z      = o_reg[6];
    assign dv_z      = o_reg[7];
    assign org_z     = o_reg[8];
    assign singular  = sing_out_reg;

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> du_x == '0 && dv_y == '0 && org_z == '0)
        else $error("singular result carries nonzero matrix");

    a_mac_dst: assert property (@(posedge clk) disable iff (!rst_n)
        mres.done |-> mres.dst <= DST_LAST)
        else $error("accumulator result tag out of range");

    a_div_phase: assert property (@(posedge clk) disable iff (!rst_n)
        ddone |-> state_reg == ST_DWAIT)
        else $error("divider finished outside the wait phase");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dbusy |-> state_reg == ST_DWAIT)
        else $error("divider running outside the wait phase");

endmodule
